// ===== design/mctp_frag_pkg.sv =====
// Shared types and constants for the MCTP message fragmenter.
// No dependencies; compiled before the interfaces and the core.
package mctp_frag_pkg;

    localparam int WORD_W = 32;
    localparam int MSG_W  = 16;
    localparam int PKT_W  = 11;
    localparam int TYPE_W = 8;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_MAX_PACKET_WORDS = 2'd0;
    localparam logic [IDX_W-1:0] REG_MESSAGE_TYPE     = 2'd1;

    localparam logic [PKT_W-1:0]  MAX_PACKET_WORDS_RST = 11'd1040;
    localparam logic [TYPE_W-1:0] MESSAGE_TYPE_RST     = 8'd19;
    localparam logic [PKT_W-1:0]  MIN_PACKET_WORDS     = 11'd3;

    localparam logic [7:0]  HDR_TYPE   = 8'h7e;
    localparam logic [15:0] HDR_VENDOR = 16'h10de;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              packet_start;
        logic [PKT_W-1:0]  packet_words;
        logic              packet_end;
        logic              message_end;
        logic              last_of_item;
    } res_t;

    // Transport header: som in 31, eom in 30, seq in 29:28, all ids zero
    function automatic logic [WORD_W-1:0] transport_hdr(input logic [1:0] seq,
                                                        input logic som,
                                                        input logic eom);
        transport_hdr = {som, eom, seq, 28'd0};
    endfunction

endpackage

// ===== design/mctp_frag_in_if.sv =====
// Request channel carrying message payload words into the fragmenter.
// Depends on mctp_frag_pkg for field widths.
interface mctp_frag_in_if;
    import mctp_frag_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] payload_word;
    logic [MSG_W-1:0]  message_words;

    modport source (output valid, output payload_word, output message_words, input ready);
    modport sink   (input valid, input payload_word, input message_words, output ready);
endinterface

// ===== design/mctp_frag_out_if.sv =====
// Request channel carrying packet words out of the fragmenter.
// Depends on mctp_frag_pkg for field widths.
interface mctp_frag_out_if;
    import mctp_frag_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              packet_start;
    logic [PKT_W-1:0]  packet_words;
    logic              packet_end;
    logic              message_end;
    logic              last_of_item;

    modport source (output valid, output out_word, output packet_start,
                    output packet_words, output packet_end, output message_end,
                    output last_of_item, input ready);
    modport sink   (input valid, input out_word, input packet_start,
                    input packet_words, input packet_end, input message_end,
                    input last_of_item, output ready);
endinterface

// ===== design/mctp_message_fragmenter_core.sv =====
// MCTP message fragmenter core: cuts a stream of payload words into MCTP packets.
// Depends on mctp_frag_pkg, mctp_frag_in_if and mctp_frag_out_if.
//
// One payload word is taken per request on msg; the first word of a message
// also carries its length. Each word yields one packet word on pkt, plus a
// transport header when it opens a packet and a vendor message header when it
// opens the message. The output side delivers one word per cycle, while pkt
// is ready, through a single output register, so a steady stream runs at one
// payload word per cycle, with requests held off while header words drain.
// Each word passes through the result buffer and then the output register.
// Size writes apply from the next packet start, type writes from the next message.
module mctp_message_fragmenter_core #(
    parameter int MAX_MESSAGE_WORDS = 65535,
    parameter int MAX_PACKET_LIMIT  = 1056
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mctp_frag_pkg::IDX_W-1:0] cfg_index,
    input  logic [mctp_frag_pkg::CFG_W-1:0] cfg_data,
    mctp_frag_in_if.sink                  msg,
    mctp_frag_out_if.source               pkt
);
    import mctp_frag_pkg::*;

    localparam logic [PKT_W-1:0] PKT_LIMIT =
        (MAX_PACKET_LIMIT > (1 << PKT_W) - 1) ? PKT_W'((1 << PKT_W) - 1)
                                              : PKT_W'(MAX_PACKET_LIMIT);
    localparam logic [MSG_W-1:0] MSG_LIMIT =
        (MAX_MESSAGE_WORDS > (1 << MSG_W) - 1) ? MSG_W'((1 << MSG_W) - 1)
                                               : MSG_W'(MAX_MESSAGE_WORDS);

    logic [PKT_W-1:0]  max_pkt_reg;
    logic [TYPE_W-1:0] msg_type_reg;
    logic [MSG_W-1:0]  rem_reg, rem_next;
    logic [PKT_W-1:0]  room_reg, room_next;
    logic [1:0]        seq_reg, seq_next;

    res_t              buf_reg [3];
    res_t              new_res [3];
    logic [1:0]        cnt_reg, new_cnt;
    res_t              out_reg;
    logic              out_valid_reg;

    logic              load, accept;
    logic [PKT_W-1:0]  maxw;
    logic [MSG_W-1:0]  n_len;
    logic [MSG_W:0]    total, need;
    logic              fits_first, fits_cont;
    logic [PKT_W-1:0]  plen_first, plen_cont;
    logic [MSG_W-1:0]  rem_a, rem_b;
    logic [PKT_W-1:0]  room_a, room_b;
    res_t              pay_res;

    assign load   = !out_valid_reg || pkt.ready;
    assign msg.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && load);
    assign accept = msg.valid && msg.ready;

    always_comb
    begin
        maxw = max_pkt_reg;
        if (maxw < MIN_PACKET_WORDS)
            maxw = MIN_PACKET_WORDS;
        if (maxw > PKT_LIMIT)
            maxw = PKT_LIMIT;

        n_len = (msg.message_words == '0) ? MSG_W'(1) : msg.message_words;
        if (n_len > MSG_LIMIT)
            n_len = MSG_LIMIT;

        total      = {1'b0, n_len} + (MSG_W+1)'(2);
        fits_first = total <= (MSG_W+1)'(maxw);
        plen_first = fits_first ? total[PKT_W-1:0] : maxw;

        need       = {1'b0, rem_reg} + (MSG_W+1)'(1);
        fits_cont  = need <= (MSG_W+1)'(maxw);
        plen_cont  = fits_cont ? need[PKT_W-1:0] : maxw;

        for (int i = 0; i < 3; i++)
            new_res[i] = '0;
        seq_next = seq_reg;
        rem_a    = rem_reg;
        room_a   = room_reg;

        if (rem_reg == '0)
        begin
            seq_next = 2'd0;
            rem_a    = n_len;
            room_a   = plen_first - PKT_W'(2);
            new_cnt  = 2'd3;
            new_res[0].out_word     = transport_hdr(2'd0, 1'b1, fits_first);
            new_res[0].packet_start = 1'b1;
            new_res[0].packet_words = plen_first;
            new_res[1].out_word     = {msg_type_reg, HDR_VENDOR, HDR_TYPE};
        end
        else if (room_reg == '0)
        begin
            seq_next = seq_reg + 2'd1;
            room_a   = plen_cont - PKT_W'(1);
            new_cnt  = 2'd2;
            new_res[0].out_word     = transport_hdr(seq_next, 1'b0, fits_cont);
            new_res[0].packet_start = 1'b1;
            new_res[0].packet_words = plen_cont;
        end
        else
        begin
            new_cnt = 2'd1;
        end

        rem_b  = rem_a - MSG_W'(1);
        room_b = room_a - PKT_W'(1);

        pay_res              = '0;
        pay_res.out_word     = msg.payload_word;
        pay_res.packet_end   = room_b == '0;
        pay_res.message_end  = rem_b == '0;
        pay_res.last_of_item = 1'b1;
        new_res[new_cnt - 2'd1] = pay_res;

        rem_next  = rem_b;
        room_next = (rem_b == '0) ? '0 : room_b;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pkt_reg  <= MAX_PACKET_WORDS_RST;
            msg_type_reg <= MESSAGE_TYPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_PACKET_WORDS: max_pkt_reg  <= cfg_data[PKT_W-1:0];
                REG_MESSAGE_TYPE:     msg_type_reg <= cfg_data[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // Fragmentation state and result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            room_reg      <= '0;
            seq_reg       <= 2'd0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rem_reg  <= rem_next;
                room_reg <= room_next;
                seq_reg  <= seq_next;
                cnt_reg  <= new_cnt;
            end
            else if (load && cnt_reg != 2'd0)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
            if (load)
                out_valid_reg <= cnt_reg != 2'd0;
        end
    end

    // Payload of buffer and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
                buf_reg[i] <= new_res[i];
        end
        else if (load)
        begin
            // advance the queue toward the head
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
        if (load)
            out_reg <= buf_reg[0];
    end

    assign pkt.valid        = out_valid_reg;
    assign pkt.out_word     = out_reg.out_word;
    assign pkt.packet_start = out_reg.packet_start;
    assign pkt.packet_words = out_reg.packet_words;
    assign pkt.packet_end   = out_reg.packet_end;
    assign pkt.message_end  = out_reg.message_end;
    assign pkt.last_of_item = out_reg.last_of_item;

endmodule
